[rtl/core/gfac_pkg.sv]
package gfac_pkg;

   localparam int unsigned GasWidth     = 14;
   localparam int unsigned HystWidth    = 10;
   localparam int unsigned ConfirmWidth = 4;
   localparam int unsigned TicksWidth   = 16;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic [ConfirmWidth-1:0] CONFIRM_LIMIT = 4'd15;
   localparam logic [TicksWidth-1:0]   TICKS_MAX     = 16'hFFFF;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_RELAY    = 3'd1,
      CMD_DOOR     = 3'd2,
      CMD_SET_MODE = 3'd3,
      CMD_SILENCE  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_GAS_THRESHOLD  = 2'd0,
      CSR_GAS_MARGIN     = 2'd1,
      CSR_CONFIRM_NEEDED = 2'd2,
      CSR_FALLBACK_TICKS = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ALERT_SAFE      = 2'd0,
      ALERT_GAS       = 2'd1,
      ALERT_FIRE      = 2'd2,
      ALERT_EMERGENCY = 2'd3
   } alert_type;

   typedef struct packed {
      logic [2:0]          command;
      logic [GasWidth-1:0] gas_level;
      logic                fire_seen;
      logic [1:0]          cmd_value;
   } req_type;

   typedef struct packed {
      logic [1:0] relay_drive;
      logic       door_drive;
      logic       buzzer_on;
      logic [1:0] alert_class;
      logic       auto_mode;
      logic       alert_changed;
      logic       notify_pulse;
      logic       led_on;
   } rsp_type;

   typedef struct packed {
      logic [GasWidth-1:0]     gas_threshold;
      logic [HystWidth-1:0]    gas_margin;
      logic [ConfirmWidth-1:0] confirm_needed;
      logic [TicksWidth-1:0]   fallback_ticks;
   } cfg_type;

   typedef struct packed {
      logic                    gas_confirmed;
      logic [ConfirmWidth-1:0] confirm_count;
      logic [1:0]              current_alert;
      logic                    mode_is_auto;
      logic [1:0]              relay_level;
      logic                    door_level;
      logic                    lamp_level;
      logic                    buzzer_level;
      logic                    silenced;
      logic                    idle_running;
      logic [TicksWidth-1:0]   idle_ticks;
   } state_type;

   localparam state_type STATE_RESET = '{mode_is_auto: 1'b1, default: '0};

endpackage

[rtl/core/gas_fire_alarm_controller_top.sv]
// Flow: a request transfer is registered in req_ff, then processed into the response
// register once it is empty or being drained; rsp_valid is driven from that register.
// Throughput: one request per cycle, limited only by rsp_ready back-pressure.
// Reset (synchronous, active high): alert state cleared to safe, auto mode,
// actuators off, configuration registers back to their default values.
module gas_fire_alarm_controller_top import gfac_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [CsrDataWidth-1:0] csr_data
);

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   req_type   req_ff;
   logic      req_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      advance;

   assign csr_ready = 1'b1;
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   gfac_step u_step (
      .req        (req_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gas_threshold  <= GasWidth'(1000);
         cfg_ff.gas_margin     <= HystWidth'(50);
         cfg_ff.confirm_needed <= ConfirmWidth'(6);
         cfg_ff.fallback_ticks <= TicksWidth'(60);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAS_THRESHOLD:  cfg_ff.gas_threshold  <= csr_data[GasWidth-1:0];
            CSR_GAS_MARGIN:     cfg_ff.gas_margin     <= csr_data[HystWidth-1:0];
            CSR_CONFIRM_NEEDED: cfg_ff.confirm_needed <= csr_data[ConfirmWidth-1:0];
            CSR_FALLBACK_TICKS: cfg_ff.fallback_ticks <= csr_data[TicksWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   a_notify_needs_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.notify_pulse |-> rsp_ff.alert_changed)
      else $error("notify without class change");

   a_safe_no_buzzer: assert property (@(posedge clock) disable iff (reset)
      state_ff.current_alert == ALERT_SAFE |-> !state_ff.buzzer_level)
      else $error("buzzer on while safe");

   a_idle_manual_only: assert property (@(posedge clock) disable iff (reset)
      state_ff.idle_running |-> !state_ff.mode_is_auto)
      else $error("idle timer running in auto mode");

   a_stalled_request_held: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_ff))
      else $error("stalled request lost");

endmodule

[rtl/core/gfac_step.sv]
module gfac_step import gfac_pkg::*; (
   input  req_type   req,
   input  cfg_type   cfg,
   input  state_type state,
   output state_type state_next,
   output rsp_type   rsp
);

   logic [GasWidth:0]       release_level;
   logic                    release_ok;
   logic [ConfirmWidth-1:0] count_inc;
   logic                    gas_conf;
   logic [1:0]              cls;
   logic                    changed;
   logic                    notify;
   logic [TicksWidth-1:0]   ticks_inc;

   always_comb begin
      state_next    = state;
      changed       = 1'b0;
      notify        = 1'b0;
      release_level = {1'b0, cfg.gas_threshold} - {5'd0, cfg.gas_margin};
      release_ok    = ({1'b0, cfg.gas_threshold} >= {5'd0, cfg.gas_margin})
                      && ({1'b0, req.gas_level} < release_level);
      count_inc     = (state.confirm_count < CONFIRM_LIMIT) ?
                      state.confirm_count + 1'b1 : state.confirm_count;
      gas_conf      = state.gas_confirmed;
      cls           = state.current_alert;
      ticks_inc     = (state.idle_ticks < TICKS_MAX) ?
                      state.idle_ticks + 1'b1 : state.idle_ticks;

      unique case (cmd_type'(req.command))
         CMD_TICK: begin
            if (req.gas_level >= cfg.gas_threshold) begin
               state_next.confirm_count = count_inc;
               if (count_inc >= cfg.confirm_needed) begin
                  gas_conf = 1'b1;
               end
            end else if (release_ok) begin
               state_next.confirm_count = '0;
               gas_conf = 1'b0;
            end
            state_next.gas_confirmed = gas_conf;
            cls     = {req.fire_seen, gas_conf};
            changed = (cls != state.current_alert);
            state_next.current_alert = cls;

            if (state.mode_is_auto && changed) begin
               state_next.relay_level = cls;
               state_next.door_level  = (cls != ALERT_SAFE);
               state_next.lamp_level  = (cls != ALERT_SAFE);
            end

            if (cls == ALERT_SAFE) begin
               state_next.buzzer_level = 1'b0;
               state_next.silenced     = 1'b0;
            end else if (!state.silenced || (changed && cls == ALERT_EMERGENCY)) begin
               state_next.buzzer_level = 1'b1;
               state_next.silenced     = 1'b0;
            end

            notify = changed && (cls != ALERT_SAFE);

            if (!state.mode_is_auto && state.relay_level == 2'd0 && !state.door_level) begin
               if (!state.idle_running) begin
                  state_next.idle_running = 1'b1;
                  state_next.idle_ticks   = '0;
               end else begin
                  state_next.idle_ticks = ticks_inc;
                  if (ticks_inc >= cfg.fallback_ticks) begin
                     state_next.mode_is_auto = 1'b1;
                     state_next.idle_running = 1'b0;
                     state_next.idle_ticks   = '0;
                  end
               end
            end else begin
               state_next.idle_running = 1'b0;
               state_next.idle_ticks   = '0;
            end
         end
         CMD_RELAY: begin
            if (!state.mode_is_auto) begin
               state_next.relay_level = req.cmd_value;
            end
         end
         CMD_DOOR: begin
            if (!state.mode_is_auto) begin
               state_next.door_level = (req.cmd_value != 2'd0);
            end
         end
         CMD_SET_MODE: begin
            state_next.mode_is_auto = (req.cmd_value == 2'd1);
            state_next.idle_running = 1'b0;
            state_next.idle_ticks   = '0;
         end
         CMD_SILENCE: begin
            if (state.current_alert != ALERT_SAFE) begin
               state_next.buzzer_level = 1'b0;
               state_next.silenced     = 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp.relay_drive   = state_next.relay_level;
      rsp.door_drive    = state_next.door_level;
      rsp.buzzer_on     = state_next.buzzer_level;
      rsp.alert_class   = state_next.current_alert;
      rsp.auto_mode     = state_next.mode_is_auto;
      rsp.alert_changed = changed;
      rsp.notify_pulse  = notify;
      rsp.led_on        = state_next.lamp_level;
   end

endmodule
